[rtl/mst_pkg.sv]
// Shared types and codes for the multi-slot timer unit.
`default_nettype none

package mst_pkg;

  // Input operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  // At most this many fired-slot beats are reported per tick
  localparam int MaxResults = 16;
  localparam int CNT_W      = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH,
    ST_SET,
    ST_REMOVE
  } mst_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the input item, restart the walk
    logic rd_issue;   // read slot at walk index, advance index
    logic finish;     // emit the closing beat of a tick
    logic do_set;     // arm the latched slot, acknowledge
    logic do_remove;  // disarm the latched slot, acknowledge
  } mst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_last;   // walk index is at the final slot
  } mst_stat_t;

endpackage

`default_nettype wire

[rtl/mst_ctrl.sv]
// Sequencer for the timer unit: accepts items and steps the slot walk.
`default_nettype none

module mst_ctrl
  import mst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_op,
  input  wire mst_stat_t  stat,
  output mst_cmd_t        cmd,
  output logic            busy
);

  mst_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          unique case (in_op)
            OP_TICK:   state_nxt = ST_WALK;
            OP_SET:    state_nxt = ST_SET;
            OP_REMOVE: state_nxt = ST_REMOVE;
            default:   state_nxt = ST_IDLE;  // unused op: no effect
          endcase
        end
      end
      ST_WALK: begin
        cmd.rd_issue = 1'b1;
        if (stat.idx_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last slot is evaluated here
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SET: begin
        cmd.do_set = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_REMOVE: begin
        cmd.do_remove = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/mst_dp.sv]
// Datapath for the timer unit: slot stores, walk pipeline and result register.
`default_nettype none

module mst_dp
  import mst_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire mst_cmd_t    cmd,
  output mst_stat_t        stat,
  input  wire logic [3:0]  in_slot,
  input  wire logic [31:0] in_period,
  input  wire logic        in_repeat_req,
  input  wire logic [31:0] in_delta_time,
  output logic             out_strobe,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_fired_slot,
  output logic             out_last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TW    = TIME_WIDTH;

  // Slot stores: {repeat, period} and elapsed, no reset
  logic [TW:0]   per_mem_r  [NUM_TIMERS];
  logic [TW-1:0] elap_mem_r [NUM_TIMERS];

  // Armed flags, cleared by reset
  logic [NUM_TIMERS-1:0] active_r, active_nxt;

  // Latched input beat
  logic [3:0]    slot_r, slot_nxt;
  logic [TW-1:0] period_r, period_nxt;
  logic          rep_r, rep_nxt;
  logic [TW-1:0] delta_r, delta_nxt;

  // Walk pipeline: read stage then evaluate stage
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] eval_idx_r, eval_idx_nxt;
  logic             eval_en_r, eval_en_nxt;
  logic [TW:0]      per_rd_r;
  logic [TW-1:0]    elap_rd_r;

  // Held fired beat, so the final one can carry last
  logic             pend_v_r, pend_v_nxt;
  logic [3:0]       pend_slot_r, pend_slot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Result register
  logic       out_strobe_r, out_strobe_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [3:0] out_slot_r, out_slot_nxt;
  logic       out_last_r, out_last_nxt;

  // Memory write port controls
  logic             per_we, elap_we;
  logic [IDX_W-1:0] elap_waddr;
  logic [TW-1:0]    elap_wdata;

  // Derived values
  logic [IDX_W+3:0] slot_wide;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_in_range;
  logic [IDX_W+3:0] eval_wide;
  logic [TW+31:0]   period_wide, delta_wide;
  logic [TW:0]      sum;
  logic [TW-1:0]    e_sat, e_new;
  logic             eval_act, eval_fire;

  // Slot number and input widths adapted to the table
  assign slot_wide     = {{IDX_W{1'b0}}, slot_r};
  assign slot_idx      = slot_wide[IDX_W-1:0];
  assign slot_in_range = ({28'd0, slot_r} < 32'(NUM_TIMERS));
  assign eval_wide     = {4'd0, eval_idx_r};
  assign period_wide   = {{TW{1'b0}}, in_period};
  assign delta_wide    = {{TW{1'b0}}, in_delta_time};

  assign stat.idx_last = (idx_r == IDX_W'(NUM_TIMERS - 1));

  // Saturating add and fire compare for the slot under evaluation
  assign sum       = {1'b0, elap_rd_r} + {1'b0, delta_r};
  assign e_sat     = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign eval_act  = eval_en_r && active_r[eval_idx_r];
  assign eval_fire = eval_act && (e_sat >= per_rd_r[TW-1:0]);
  assign e_new     = (eval_fire && per_rd_r[TW]) ? '0 : e_sat;

  // Write port selection
  assign per_we     = cmd.do_set && slot_in_range;
  assign elap_we    = per_we || eval_act;
  assign elap_waddr = cmd.do_set ? slot_idx : eval_idx_r;
  assign elap_wdata = cmd.do_set ? '0 : e_new;

  // Next-state logic
  always_comb begin
    active_nxt     = active_r;
    slot_nxt       = slot_r;
    period_nxt     = period_r;
    rep_nxt        = rep_r;
    delta_nxt      = delta_r;
    idx_nxt        = idx_r;
    eval_idx_nxt   = idx_r;
    eval_en_nxt    = cmd.rd_issue;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;

    // Accept: latch the beat and restart the walk
    if (cmd.capture) begin
      slot_nxt   = in_slot;
      period_nxt = period_wide[TW-1:0];
      rep_nxt    = in_repeat_req;
      delta_nxt  = delta_wide[TW-1:0];
      idx_nxt    = '0;
      pend_v_nxt = 1'b0;
      cnt_nxt    = '0;
    end

    if (cmd.rd_issue) begin
      idx_nxt = IDX_W'(idx_r + 1'b1);
    end

    // One-shot slot disarms when it fires
    if (eval_fire && !per_rd_r[TW]) begin
      active_nxt[eval_idx_r] = 1'b0;
    end

    // Report fired slot: release the held beat, hold the new one
    if (eval_fire && (cnt_r < CNT_W'(MaxResults))) begin
      if (pend_v_r) begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_FIRED;
        out_slot_nxt   = pend_slot_r;
        out_last_nxt   = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_slot_nxt = eval_wide[3:0];
      cnt_nxt       = CNT_W'(cnt_r + 1'b1);
    end

    // Closing beat of a tick
    if (cmd.finish) begin
      out_strobe_nxt = 1'b1;
      out_last_nxt   = 1'b1;
      if (pend_v_r) begin
        out_kind_nxt = KIND_FIRED;
        out_slot_nxt = pend_slot_r;
      end else begin
        out_kind_nxt = KIND_DONE;
        out_slot_nxt = 4'd0;
      end
      pend_v_nxt = 1'b0;
    end

    // Set and remove, acknowledged even out of range
    if (cmd.do_set || cmd.do_remove) begin
      if (slot_in_range) begin
        active_nxt[slot_idx] = cmd.do_set;
      end
      out_strobe_nxt = 1'b1;
      out_kind_nxt   = KIND_ACK;
      out_slot_nxt   = slot_r;
      out_last_nxt   = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      eval_en_r    <= 1'b0;
      pend_v_r     <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      active_r     <= active_nxt;
      eval_en_r    <= eval_en_nxt;
      pend_v_r     <= pend_v_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    period_r    <= period_nxt;
    rep_r       <= rep_nxt;
    delta_r     <= delta_nxt;
    eval_idx_r  <= eval_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Period store: written on set, read during the walk
  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem_r[slot_idx] <= {rep_r, period_r};
    end
    if (cmd.rd_issue) begin
      per_rd_r <= per_mem_r[idx_r];
    end
  end

  // Elapsed store: cleared on set, written back by the evaluate stage
  always_ff @(posedge clk) begin
    if (elap_we) begin
      elap_mem_r[elap_waddr] <= elap_wdata;
    end
    if (cmd.rd_issue) begin
      elap_rd_r <= elap_mem_r[idx_r];
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_kind       = out_kind_r;
  assign out_fired_slot = out_slot_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

[rtl/multi_slot_software_timer_unit.sv]
// Top level of the multi-slot timer unit: sequencer plus datapath.
//
//   channel  direction  beat taken when       fields
//   in_      input      start && !busy        op, slot, period, repeat_req, delta_time
//   out_     output     out_strobe (1 cycle)  kind, fired_slot, last
//
// A set or remove keeps busy high only while in its SET or REMOVE state; its
// acknowledge beat is registered there and is on the ports in the cycle after.
// A tick keeps busy high through the WALK, DRAIN and FINISH states: the walk
// reads one slot per cycle from the period and elapsed stores, evaluates it
// the cycle after, and the FINISH state emits the beat that carries last.
// Unused op codes are dropped without going busy.
// Reset (rst_n low, synchronous) disarms every slot; no clearing pass.
// The receiver cannot stall; each result beat is on the ports for one cycle.
`default_nettype none

module multi_slot_software_timer_unit
  import mst_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [3:0]  in_slot,
  input  wire logic [31:0] in_period,
  input  wire logic        in_repeat_req,
  input  wire logic [31:0] in_delta_time,
  output logic             out_strobe,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_fired_slot,
  output logic             out_last
);

  mst_cmd_t  cmd;
  mst_stat_t stat;

  mst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mst_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_slot        (in_slot),
    .in_period      (in_period),
    .in_repeat_req  (in_repeat_req),
    .in_delta_time  (in_delta_time),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_fired_slot (out_fired_slot),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the multi-slot timer unit: directed and random commands.
`default_nettype none

module tb_top;
  import mst_pkg::*;

  localparam int NumSlots    = 16;
  localparam int RandomItems = 500;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 24;    // a full tick walk plus margin
  localparam int PrintCap    = 50;

  // op code the block drops without going busy
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic       last;
  } timer_beat_t;

  // Slot table predictor plus the queue of beats it says are still due
  class timer_table_sb;
    bit          armed      [NumSlots];
    bit          periodic   [NumSlots];
    logic [31:0] period_of  [NumSlots];
    logic [31:0] elapsed_of [NumSlots];
    timer_beat_t due_beats[$];
    int errors;
    int fired_beats;
    int done_beats;
    int ack_beats;

    function void note_command(logic [1:0] op, logic [3:0] slot, logic [31:0] period,
                               logic rep, logic [31:0] delta);
      logic [32:0] sum;
      logic [31:0] e;
      int          hits;
      timer_beat_t b;
      hits = 0;
      case (op)
        OP_TICK: begin
          for (int i = 0; i < NumSlots; i++) begin
            if (armed[i]) begin
              // saturating add of the elapsed time
              sum = {1'b0, elapsed_of[i]} + {1'b0, delta};
              e   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              if (e >= period_of[i]) begin
                if (periodic[i]) e = '0;
                else armed[i] = 1'b0;
                if (hits < MaxResults) begin
                  b.kind = KIND_FIRED;
                  b.slot = 4'(i);
                  b.last = 1'b0;
                  due_beats.push_back(b);
                end
                hits++;
              end
              elapsed_of[i] = e;
            end
          end
          if (hits == 0) begin
            b.kind = KIND_DONE;
            b.slot = '0;
            b.last = 1'b1;
            due_beats.push_back(b);
          end else begin
            // last fired beat closes the tick
            b = due_beats.pop_back();
            b.last = 1'b1;
            due_beats.push_back(b);
          end
        end
        OP_SET, OP_REMOVE: begin
          if (int'(slot) < NumSlots) begin
            if (op == OP_SET) begin
              armed[slot]      = 1'b1;
              periodic[slot]   = rep;
              period_of[slot]  = period;
              elapsed_of[slot] = '0;
            end else begin
              armed[slot] = 1'b0;
            end
          end
          b.kind = KIND_ACK;
          b.slot = slot;
          b.last = 1'b1;
          due_beats.push_back(b);
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string msg);
      if (errors < PrintCap) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_beat(logic [1:0] kind, logic [3:0] slot, logic last);
      timer_beat_t want;
      if (due_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d slot %0d last %0d",
                                kind, slot, last));
        return;
      end
      want = due_beats.pop_front();
      if (kind !== want.kind)
        flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (slot !== want.slot)
        flag_mismatch($sformatf("fired_slot %0d, want %0d", slot, want.slot));
      if (last !== want.last)
        flag_mismatch($sformatf("last %0d, want %0d", last, want.last));
      case (want.kind)
        KIND_FIRED: fired_beats++;
        KIND_DONE:  done_beats++;
        default:    ack_beats++;
      endcase
    endtask
  endclass

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic [1:0]  in_op         = OP_TICK;
  logic [3:0]  in_slot       = '0;
  logic [31:0] in_period     = '0;
  logic        in_repeat_req = 1'b0;
  logic [31:0] in_delta_time = '0;
  logic        busy;
  logic        out_strobe;
  logic [1:0]  out_kind;
  logic [3:0]  out_fired_slot;
  logic        out_last;

  timer_table_sb sb = new;
  int idle_pct     = 13;
  int cmd_count    = 0;
  int ignored_count = 0;

  multi_slot_software_timer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_slot        (in_slot),
    .in_period      (in_period),
    .in_repeat_req  (in_repeat_req),
    .in_delta_time  (in_delta_time),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_fired_slot (out_fired_slot),
    .out_last       (out_last)
  );

  // 10-unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor: every strobed beat is checked at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_beat(out_kind, out_fired_slot, out_last);
  end

  // Drive one command beat, with a random idle gap ahead of it
  task automatic send_item(logic [1:0] op, logic [3:0] slot, logic [31:0] period,
                           logic rep, logic [31:0] delta);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_slot       <= slot;
    in_period     <= period;
    in_repeat_req <= rep;
    in_delta_time <= delta;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_command(op, slot, period, rep, delta);
    if (op == OP_UNUSED) ignored_count++;
    else cmd_count++;
  endtask

  task automatic tick(logic [31:0] delta);
    send_item(OP_TICK, 4'($urandom), $urandom, 1'($urandom), delta);
  endtask

  task automatic set_slot(logic [3:0] slot, logic [31:0] period, logic rep);
    send_item(OP_SET, slot, period, rep, $urandom);
  endtask

  task automatic remove_slot(logic [3:0] slot);
    send_item(OP_REMOVE, slot, $urandom, 1'($urandom), $urandom);
  endtask

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[%0t] timeout after %0d cycles, %0d beats outstanding",
             $time, cycles, sb.due_beats.size());
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int          roll;
    int          pick;
    logic [31:0] value;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, idle remove, dropped op code
    tick(32'd0);
    remove_slot(4'd5);
    send_item(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // zero period fires at once, one-shot then disarms
    set_slot(4'd0, 32'd0, 1'b0);
    tick(32'd0);
    tick(32'd0);
    // saturation at the top of the time range
    set_slot(4'd15, 32'hFFFF_FFFF, 1'b1);
    set_slot(4'd7, 32'hFFFF_FFFE, 1'b0);
    tick(32'h8000_0000);
    tick(32'hFFFF_FFFF);
    // rearm of an armed slot; periodic restart drops overshoot
    set_slot(4'd15, 32'd5, 1'b1);
    tick(32'd7);
    tick(32'd4);
    tick(32'd1);
    remove_slot(4'd15);
    tick(32'd10);

    // random traffic: sender idling 13%, then 76%, then none
    while (cmd_count < RandomItems) begin
      if (cmd_count < RandomItems / 3) idle_pct = 13;
      else if (cmd_count < 2 * RandomItems / 3) idle_pct = 76;
      else idle_pct = 0;
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      if (roll < 4) begin
        send_item(OP_UNUSED, 4'($urandom), $urandom, 1'($urandom), $urandom);
      end else if (roll < 7) begin
        // arm the whole table with short periods so many fire together
        for (int s = 0; s < NumSlots; s++) set_slot(4'(s), $urandom_range(3), 1'($urandom));
        tick($urandom_range(4));
      end else if (roll < 40) begin
        if (pick < 70) value = $urandom_range(40);
        else if (pick < 85) value = $urandom;
        else value = 32'hFFFF_FFFF - $urandom_range(3);
        set_slot(4'($urandom), value, 1'($urandom));
      end else if (roll < 55) begin
        remove_slot(4'($urandom));
      end else begin
        if (pick < 75) value = $urandom_range(15);
        else if (pick < 90) value = $urandom;
        else value = 32'hFFFF_FFFF - $urandom_range(3);
        tick(value);
      end
    end
    start <= 1'b0;

    // let outstanding beats land, then watch for strays
    while (sb.due_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("summary: %0d commands taken, %0d dropped op codes", cmd_count, ignored_count);
    $display("summary: beats checked: %0d fired, %0d tick done, %0d acks, %0d mismatches",
             sb.fired_beats, sb.done_beats, sb.ack_beats, sb.errors);
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/mst_pkg.sv
rtl/mst_ctrl.sv
rtl/mst_dp.sv
rtl/multi_slot_software_timer_unit.sv
bench/tb_top.sv
